### rtl/core/fbfl_pkg.sv
// shared types and constants of the fixed block free-list allocator
`timescale 1ns / 1ps
`default_nettype none
package fbfl_pkg;

    localparam int BLOCKS = 256;
    localparam int IDX_W  = 8;
    localparam int CNT_W  = 9;
    localparam int LINK_W = 9;

    localparam logic       OP_ALLOC = 1'b0;
    localparam logic       OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic             opcode;
        logic [IDX_W-1:0] free_index;
    } req_word_t;

    typedef struct packed {
        logic [IDX_W-1:0] block_index;
        logic [1:0]       status;
        logic [CNT_W-1:0] free_count;
    } rsp_word_t;

    // controller to datapath
    typedef struct packed {
        logic exec;
        logic pop_finish;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_pop;
    } dp_stat_t;

endpackage
`default_nettype wire

### rtl/core/fbfl_ram.sv
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps
`default_nettype none
module fbfl_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

### rtl/core/fbfl_ctrl.sv
// allocator controller: handshake and sequencing of stack pops
`timescale 1ns / 1ps
`default_nettype none
module fbfl_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output fbfl_pkg::dp_cmd_t       cmd,
    input  wire fbfl_pkg::dp_stat_t stat
);
    import fbfl_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_POP
    } state_t;

    state_t state_reg;
    logic   rsp_valid_reg;
    logic   slot_free;
    logic   accept;

    // output slot is free or its word leaves this cycle
    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !((state_reg == S_IDLE) && slot_free);
    assign accept    = req_valid && !req_stall;

    assign cmd.exec       = accept;
    assign cmd.pop_finish = (state_reg == S_POP);
    assign rsp_valid      = rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && stat.need_pop)
                    begin
                        state_reg     <= S_POP;
                        rsp_valid_reg <= 1'b0;
                    end
                    else if (accept)
                    begin
                        rsp_valid_reg <= 1'b1;
                    end
                    else if (rsp_valid_reg && !rsp_stall)
                    begin
                        rsp_valid_reg <= 1'b0;
                    end
                end
                S_POP:
                begin
                    // link read data is back, result goes out
                    state_reg     <= S_IDLE;
                    rsp_valid_reg <= 1'b1;
                end
                default:
                begin
                    state_reg     <= S_IDLE;
                    rsp_valid_reg <= 1'b0;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### rtl/core/fbfl_dp.sv
// allocator datapath: stack head, high-water mark, free count, link ram
`timescale 1ns / 1ps
`default_nettype none
module fbfl_dp (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [8:0]          cfg_wdata,
    input  wire fbfl_pkg::req_word_t req_word,
    output fbfl_pkg::rsp_word_t      rsp_word,
    input  wire fbfl_pkg::dp_cmd_t   cmd,
    output fbfl_pkg::dp_stat_t       stat
);
    import fbfl_pkg::*;

    logic [CNT_W-1:0] num_reg,  num_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic             nonempty_reg, nonempty_next;
    logic [CNT_W-1:0] hw_reg,   hw_next;
    logic [CNT_W-1:0] fb_reg,   fb_next;
    rsp_word_t        rsp_reg,  rsp_next;
    logic             rsp_load;

    logic             ram_we;
    logic [LINK_W-1:0] ram_wdata;
    logic             ram_re;
    logic [LINK_W-1:0] ram_rdata;
    logic [CNT_W-1:0] cfg_clamped;
    logic [CNT_W-1:0] fb_dec;
    logic             need_pop;

    assign need_pop      = (req_word.opcode == OP_ALLOC) && nonempty_reg;
    assign stat.need_pop = need_pop;

    // saturating decrement shared by both alloc paths
    assign fb_dec = (fb_reg != '0) ? fb_reg - 1'b1 : fb_reg;

    always_comb
    begin
        if (cfg_wdata == '0)
        begin
            cfg_clamped = CNT_W'(1);
        end
        else if (cfg_wdata > CNT_W'(BLOCKS))
        begin
            cfg_clamped = CNT_W'(BLOCKS);
        end
        else
        begin
            cfg_clamped = cfg_wdata;
        end
    end

    always_comb
    begin
        num_next      = num_reg;
        head_next     = head_reg;
        nonempty_next = nonempty_reg;
        hw_next       = hw_reg;
        fb_next       = fb_reg;
        rsp_next      = rsp_reg;
        rsp_load      = 1'b0;
        ram_we        = 1'b0;
        ram_wdata     = nonempty_reg ? LINK_W'({1'b0, head_reg} + 9'd1) : '0;
        ram_re        = 1'b0;

        if (cfg_we)
        begin
            num_next      = cfg_clamped;
            head_next     = '0;
            nonempty_next = 1'b0;
            hw_next       = '0;
            fb_next       = cfg_clamped;
        end
        else if (cmd.pop_finish)
        begin
            // head was handed out, link says what lies below it
            if ((ram_rdata != '0) && (ram_rdata <= LINK_W'(BLOCKS)))
            begin
                head_next     = IDX_W'(ram_rdata - 1'b1);
                nonempty_next = 1'b1;
            end
            else
            begin
                head_next     = '0;
                nonempty_next = 1'b0;
            end
            fb_next  = fb_dec;
            rsp_next = '{block_index: head_reg, status: ST_OK, free_count: fb_dec};
            rsp_load = 1'b1;
        end
        else if (cmd.exec)
        begin
            if (req_word.opcode == OP_FREE)
            begin
                rsp_load = 1'b1;
                if ({1'b0, req_word.free_index} >= num_reg)
                begin
                    rsp_next = '{block_index: '0, status: ST_RANGE, free_count: fb_reg};
                end
                else
                begin
                    ram_we        = 1'b1;
                    head_next     = req_word.free_index;
                    nonempty_next = 1'b1;
                    if (fb_reg < num_reg)
                    begin
                        fb_next = fb_reg + 1'b1;
                    end
                    rsp_next = '{block_index: '0, status: ST_OK, free_count: fb_next};
                end
            end
            else if (need_pop)
            begin
                ram_re = 1'b1;
            end
            else if (hw_reg < num_reg)
            begin
                hw_next  = hw_reg + 1'b1;
                fb_next  = fb_dec;
                rsp_next = '{block_index: hw_reg[IDX_W-1:0], status: ST_OK,
                             free_count: fb_dec};
                rsp_load = 1'b1;
            end
            else
            begin
                rsp_next = '{block_index: '0, status: ST_EMPTY, free_count: fb_reg};
                rsp_load = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg      <= CNT_W'(BLOCKS);
            head_reg     <= '0;
            nonempty_reg <= 1'b0;
            hw_reg       <= '0;
            fb_reg       <= CNT_W'(BLOCKS);
        end
        else
        begin
            num_reg      <= num_next;
            head_reg     <= head_next;
            nonempty_reg <= nonempty_next;
            hw_reg       <= hw_next;
            fb_reg       <= fb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_word = rsp_reg;

    fbfl_ram #(
        .WIDTH (LINK_W),
        .DEPTH (BLOCKS)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (req_word.free_index),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

endmodule
`default_nettype wire

### rtl/core/fixed_block_free_list_allocator_top.sv
// Fixed-size block allocator over 256 numbered blocks with a LIFO free list.
// An alloc word hands out the most recently freed block, or else the lowest
// block never handed out; a free word pushes its index, and an index at or
// above num_blocks is reported and ignored. Double frees are not caught.
// Each word yields one result word, held in an output register. A free, or an
// alloc with no freed block waiting, loads that register when accepted; an
// alloc that pops a freed block goes through the pop state, which waits for
// the registered read of the next-link ram, and loads it from there. A new
// word is accepted while the previous result waits only if that result is
// taken in the same cycle.
// Writing num_blocks resets the pool to blocks 0..num_blocks-1 ascending;
// the link ram needs no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
module fixed_block_free_list_allocator_top (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [8:0]           cfg_wdata,
    input  wire logic                 req_valid,
    output logic                      req_stall,
    input  wire fbfl_pkg::req_word_t  req_word,
    output logic                      rsp_valid,
    input  wire logic                 rsp_stall,
    output fbfl_pkg::rsp_word_t       rsp_word
);
    import fbfl_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    fbfl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    fbfl_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_word  (req_word),
        .rsp_word  (rsp_word),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
`default_nettype wire

### rtl/core/fbfl_checker.sv
// port-level checks of the allocator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module fbfl_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                cfg_we,
    input wire logic [8:0]          cfg_wdata,
    input wire logic                req_valid,
    input wire logic                req_stall,
    input wire fbfl_pkg::req_word_t req_word,
    input wire logic                rsp_valid,
    input wire logic                rsp_stall,
    input wire fbfl_pkg::rsp_word_t rsp_word
);
    import fbfl_pkg::*;

    // a word waiting at the output holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
        else $error("result word changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_word.status == ST_OK || rsp_word.status == ST_EMPTY ||
                       rsp_word.status == ST_RANGE))
        else $error("undefined status code");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_word.free_count <= CNT_W'(BLOCKS))
        else $error("free count above pool size");

    a_fail_index: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.status != ST_OK |-> rsp_word.block_index == '0)
        else $error("failed operation returned a block index");

    // an empty pool never reports free blocks
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.status == ST_EMPTY |-> rsp_word.free_count == '0)
        else $error("pool empty with nonzero free count");

endmodule

bind fixed_block_free_list_allocator_top fbfl_checker u_fbfl_checker (.*);
`default_nettype wire

### test/fbfl_alloc_check.sv
// checker for the free-list allocator: tracks the pool, predicts and compares result words
`timescale 1ns / 1ps
module fbfl_alloc_check
    import fbfl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic [8:0] cfg_wdata,
    input  logic      req_valid,
    input  logic      req_stall,
    input  req_word_t req_word,
    input  logic      rsp_valid,
    input  logic      rsp_stall,
    input  rsp_word_t rsp_word,
    output int        fail_count,
    output int        words_due
);

    logic [8:0] pool_blocks;
    logic [8:0] pool_free;
    logic [8:0] fresh_next;
    logic [7:0] top_blk;
    logic       top_valid;
    logic [8:0] link_mem [BLOCKS];

    rsp_word_t  due_q [$];

    task automatic clear_pool();
        top_blk    = '0;
        top_valid  = 1'b0;
        fresh_next = '0;
        pool_free  = pool_blocks;
        for (int i = 0; i < BLOCKS; i++)
        begin
            link_mem[i] = '0;
        end
    endtask

    task automatic resize_pool(input logic [8:0] value);
        logic [8:0] v;
        v = value;
        if (v == 9'd0)
        begin
            v = 9'd1;
        end
        if (v > 9'(BLOCKS))
        begin
            v = 9'(BLOCKS);
        end
        pool_blocks = v;
        clear_pool();
    endtask

    task automatic alloc_or_free(input req_word_t w, output rsp_word_t r);
        logic [8:0] link;
        r.block_index = '0;
        r.status      = ST_OK;
        if (w.opcode == OP_ALLOC)
        begin
            if (top_valid)
            begin
                // pop the most recently freed block
                r.block_index = top_blk;
                link          = link_mem[top_blk];
                if (link != 9'd0)
                begin
                    top_blk = 8'(link - 9'd1);
                end
                else
                begin
                    top_blk   = '0;
                    top_valid = 1'b0;
                end
                if (pool_free != 9'd0)
                begin
                    pool_free = pool_free - 9'd1;
                end
            end
            else if (fresh_next < pool_blocks)
            begin
                r.block_index = fresh_next[7:0];
                fresh_next    = fresh_next + 9'd1;
                if (pool_free != 9'd0)
                begin
                    pool_free = pool_free - 9'd1;
                end
            end
            else
            begin
                r.status = ST_EMPTY;
            end
        end
        else
        begin
            if ({1'b0, w.free_index} >= pool_blocks)
            begin
                r.status = ST_RANGE;
            end
            else
            begin
                link_mem[w.free_index] = top_valid ? {1'b0, top_blk} + 9'd1 : 9'd0;
                top_blk   = w.free_index;
                top_valid = 1'b1;
                // double frees can push past the pool size, the count saturates
                if (pool_free < pool_blocks)
                begin
                    pool_free = pool_free + 9'd1;
                end
            end
        end
        r.free_count = pool_free;
    endtask

    function automatic void check_field(string fld, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d got %0d", $time, fld, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_word_t want;
        rsp_word_t made;
        if (!rst_n)
        begin
            fail_count = 0;
            due_q.delete();
            resize_pool(9'(BLOCKS));
        end
        else
        begin
            // the result leaving now always belongs to an older word than one entering
            if (rsp_valid && !rsp_stall)
            begin
                if (due_q.size() == 0)
                begin
                    $display("%0t: result word with nothing outstanding, expected none got %h",
                             $time, rsp_word);
                    fail_count++;
                end
                else
                begin
                    want = due_q.pop_front();
                    check_field("block_index", want.block_index, rsp_word.block_index);
                    check_field("status", want.status, rsp_word.status);
                    check_field("free_count", want.free_count, rsp_word.free_count);
                end
            end
            if (cfg_we)
            begin
                resize_pool(cfg_wdata);
            end
            if (req_valid && !req_stall)
            begin
                alloc_or_free(req_word, made);
                due_q.push_back(made);
            end
        end
        words_due = due_q.size();
    end

endmodule

### test/tb_fixed_block_free_list_allocator_top.sv
// testbench top: stimulus, stall pattern and verdict for the free-list allocator
`timescale 1ns / 1ps
module tb_fixed_block_free_list_allocator_top;
    import fbfl_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic [8:0] cfg_wdata;
    logic      req_valid;
    logic      req_stall;
    req_word_t req_word;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_word_t rsp_word;

    int        fail_count;
    int        words_due;
    int        pool_now;
    int        stall_run = 0;
    int        stall_len;

    fixed_block_free_list_allocator_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    fbfl_alloc_check u_alloc_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_word   (req_word),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_word   (rsp_word),
        .fail_count (fail_count),
        .words_due  (words_due)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        else if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // result side: stall runs mixed with long stall-free stretches
    always @(negedge clk)
    begin
        if (stall_run > 0)
        begin
            stall_run = stall_run - 1;
        end
        else if (rsp_stall)
        begin
            rsp_stall <= 1'b0;
            stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                    : $urandom_range(0, 10);
        end
        else
        begin
            stall_len = pick_gap();
            if (stall_len > 0)
            begin
                rsp_stall <= 1'b1;
                stall_run = stall_len - 1;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input logic op, input logic [7:0] idx, input int gap);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid           <= 1'b1;
        req_word.opcode     <= op;
        req_word.free_index <= idx;
        do
        begin
            @(posedge clk);
        end
        while (req_stall);
        @(negedge clk);
    endtask

    task automatic set_pool_blocks(input logic [8:0] value);
        req_valid <= 1'b0;
        wait (words_due == 0);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        pool_now = (value == 9'd0) ? 1 : ((value > 9'(BLOCKS)) ? BLOCKS : int'(value));
    endtask

    // bursts leaning toward alloc or free, or evenly mixed, so the stack grows deep and drains to empty
    task automatic run_phase(input int count);
        int         left;
        int         burst;
        int         lean;
        bit         calm;
        logic       op;
        logic [7:0] idx;
        left = count;
        while (left > 0)
        begin
            lean  = $urandom_range(0, 2);
            burst = $urandom_range(1, pool_now + 4);
            if (burst > left)
            begin
                burst = left;
            end
            calm = ($urandom_range(0, 4) == 0);
            repeat (burst)
            begin
                case (lean)
                    0: op = ($urandom_range(0, 9) == 0) ? OP_FREE : OP_ALLOC;
                    1: op = ($urandom_range(0, 4) == 0) ? OP_ALLOC : OP_FREE;
                    default: op = 1'($urandom_range(0, 1));
                endcase
                if ($urandom_range(0, 6) == 0)
                begin
                    idx = 8'($urandom_range(0, 255));
                end
                else
                begin
                    idx = 8'($urandom_range(0, pool_now - 1));
                end
                send_word(op, idx, calm ? 0 : pick_gap());
            end
            left -= burst;
        end
    endtask

    initial
    begin
        int sizes [9];
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        req_valid = 1'b0;
        req_word  = '0;
        pool_now  = BLOCKS;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // full pool after reset: fresh blocks, free of an untouched block, lifo pops
        send_word(OP_ALLOC, 8'hff, 0);
        send_word(OP_ALLOC, 8'h00, 0);
        send_word(OP_ALLOC, 8'h5a, 2);
        send_word(OP_FREE, 8'd255, 0);
        send_word(OP_FREE, 8'd0, 0);
        send_word(OP_ALLOC, 8'ha5, 1);
        send_word(OP_ALLOC, 8'h00, 0);
        send_word(OP_ALLOC, 8'hff, 0);

        // two blocks: range errors, empty pool, double free looping at zero count
        set_pool_blocks(9'd2);
        send_word(OP_FREE, 8'd2, 0);
        send_word(OP_FREE, 8'd255, 0);
        send_word(OP_ALLOC, 8'h00, 0);
        send_word(OP_ALLOC, 8'h00, 0);
        send_word(OP_ALLOC, 8'h00, 0);
        send_word(OP_FREE, 8'd1, 0);
        send_word(OP_FREE, 8'd1, 0);
        send_word(OP_ALLOC, 8'h00, 0);
        send_word(OP_ALLOC, 8'h00, 0);
        send_word(OP_ALLOC, 8'h00, 3);

        // zero written is taken as one block
        set_pool_blocks(9'd0);
        send_word(OP_ALLOC, 8'h00, 0);
        send_word(OP_ALLOC, 8'h00, 0);
        send_word(OP_FREE, 8'd0, 0);
        send_word(OP_FREE, 8'd1, 0);
        send_word(OP_ALLOC, 8'hff, 0);

        sizes[0] = 256;
        sizes[1] = 511;
        sizes[2] = 1;
        sizes[3] = 3;
        sizes[4] = 16;
        sizes[5] = 100;
        sizes[6] = 0;
        sizes[7] = 255;
        sizes[8] = $urandom_range(2, 200);
        foreach (sizes[i])
        begin
            set_pool_blocks(9'(sizes[i]));
            run_phase(60 + pool_now * 3 / 4);
        end

        req_valid <= 1'b0;
        wait (words_due == 0);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("tb_fixed_block_free_list_allocator_top: clean");
        end
        else
        begin
            $display("tb_fixed_block_free_list_allocator_top: errors");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("tb_fixed_block_free_list_allocator_top: errors");
        $finish;
    end

endmodule
